// ===== rtl/core/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the process scheduler.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned MaxProcsDef = 16;
  localparam logic [2:0] PolicyReset  = 3'd5;
  localparam logic [7:0] QuantumReset = 8'd2;
  localparam logic [9:0] HorizonReset = 10'd50;

  // configuration register indexes
  localparam logic [1:0] CfgPolicy  = 2'd0;
  localparam logic [1:0] CfgQuantum = 2'd1;
  localparam logic [1:0] CfgHorizon = 2'd2;

  // policy codes
  localparam logic [2:0] PolFcfs  = 3'd0;
  localparam logic [2:0] PolSjf   = 3'd1;
  localparam logic [2:0] PolPrio  = 3'd2;
  localparam logic [2:0] PolPrioP = 3'd3;
  localparam logic [2:0] PolRr    = 3'd4;
  localparam logic [2:0] PolRrAge = 3'd5;

  // entry phases
  localparam logic [1:0] PhNew   = 2'd0;
  localparam logic [1:0] PhReady = 2'd1;
  localparam logic [1:0] PhRun   = 2'd2;
  localparam logic [1:0] PhDone  = 2'd3;

  // controller commands to the datapath
  typedef struct packed {
    logic load;     // write new entry
    logic retire;   // retire / preempt step
    logic admit;    // examine entry at scan index
    logic sel;      // compare ready slot at scan index
    logic shift;    // remove chosen slot, one slot per cycle
    logic dispatch; // start chosen process
    logic run;      // account run time
    logic age;      // age ready slot at scan index
    logic finish;   // advance clock, capture result
    logic tick;     // result being captured belongs to a tick
    logic clr_scan; // reset scan index
    logic inc_scan; // advance scan index
  } cps_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan index at end of range for current phase
    logic shift_last; // shift walk done
    logic busy;       // cpu busy
    logic ready_any;  // ready count nonzero
    logic tick_live;  // clock below horizon
  } cps_sts_t;

endpackage

// ===== rtl/core/cps_datapath.sv =====
// ----------------------------------------------------------------------------
// cps_datapath
// Process table, ready order and scan unit, stepped by the controller.
// ----------------------------------------------------------------------------
module cps_datapath #(
  parameter int unsigned MaxProcs = cps_pkg::MaxProcsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cps_pkg::cps_cmd_t cmd_i,
  output cps_pkg::cps_sts_t sts_o,
  input  logic [2:0]       policy_i,
  input  logic [7:0]       quantum_i,
  input  logic [9:0]       horizon_i,
  input  logic [9:0]       arrival_at_i,
  input  logic [9:0]       burst_len_i,
  input  logic [7:0]       base_prio_i,
  output logic [9:0]       time_now_o,
  output logic             run_valid_o,
  output logic [3:0]       run_id_o,
  output logic             done_valid_o,
  output logic [3:0]       done_id_o,
  output logic             all_done_o,
  output logic             load_reject_o
);
  import cps_pkg::*;

  localparam int unsigned IdW  = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW = $clog2(MaxProcs + 1);

  logic [9:0]  arr_q   [MaxProcs];
  logic [9:0]  burst_q [MaxProcs];
  logic [7:0]  prio_q  [MaxProcs];
  logic [7:0]  age_q   [MaxProcs];
  logic [9:0]  ran_q   [MaxProcs];
  logic [7:0]  slice_q [MaxProcs];
  logic [1:0]  phase_q [MaxProcs];
  logic [IdW-1:0] order_q [MaxProcs];

  logic [CntW-1:0] ready_cnt_q, loaded_q, fin_q, scan_q;
  logic [IdW-1:0]  cpu_id_q, best_id_q;
  logic [CntW-1:0] best_pos_q;
  logic signed [10:0] best_key_q;
  logic [9:0]  clock_q;
  logic        busy_q;
  logic        done_v_q, rej_q;
  logic [IdW-1:0] done_i_q;

  logic [2:0] pol;
  logic       rr;
  logic [IdW-1:0] scan_id, slot_id, cur_id;
  logic signed [10:0] key;
  logic       push_pre;
  logic       sel_win;
  logic       admit_hit;

  assign pol     = (policy_i > PolRrAge) ? PolFcfs : policy_i;
  assign rr      = (pol == PolRr) || (pol == PolRrAge);
  assign scan_id = scan_q[IdW-1:0];
  assign slot_id = order_q[scan_id];

  // selection key of the ready slot under scan
  always_comb begin
    unique case (pol)
      PolSjf:             key = signed'({1'b0, burst_q[slot_id]});
      PolPrio, PolPrioP:  key = signed'({3'b0, prio_q[slot_id]});
      PolRrAge:           key = signed'({3'b0, prio_q[slot_id]})
                              - signed'({3'b0, age_q[slot_id]});
      default:            key = '0;
    endcase
  end

  assign push_pre = (ran_q[cpu_id_q] != burst_q[cpu_id_q])
                    && ((pol == PolPrioP) || (rr && slice_q[cpu_id_q] >= quantum_i));
  assign cur_id   = best_id_q;

  // slot under scan beats the best so far; first slot always wins
  assign sel_win  = (scan_q == '0) || (key < best_key_q);

  // loaded entry under scan arrives now
  assign admit_hit = cmd_i.admit && (scan_q < loaded_q) && phase_q[scan_id] == PhNew
                     && arr_q[scan_id] == clock_q && ready_cnt_q < CntW'(MaxProcs);

  assign sts_o.scan_last  = cmd_i.admit ? (scan_q + 1'b1 >= loaded_q)
                                        : (scan_q + 1'b1 >= ready_cnt_q);
  assign sts_o.shift_last = (scan_q + 1'b1 >= ready_cnt_q);
  assign sts_o.busy       = busy_q;
  assign sts_o.ready_any  = ready_cnt_q != '0;
  assign sts_o.tick_live  = clock_q < horizon_i;

  // table and sequencing state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && loaded_q < CntW'(MaxProcs)) begin
      arr_q[loaded_q[IdW-1:0]]   <= arrival_at_i;
      burst_q[loaded_q[IdW-1:0]] <= burst_len_i;
      prio_q[loaded_q[IdW-1:0]]  <= base_prio_i;
      age_q[loaded_q[IdW-1:0]]   <= '0;
      ran_q[loaded_q[IdW-1:0]]   <= '0;
      slice_q[loaded_q[IdW-1:0]] <= '0;
      phase_q[loaded_q[IdW-1:0]] <= PhNew;
    end
    if (cmd_i.retire && busy_q) begin
      if (ran_q[cpu_id_q] == burst_q[cpu_id_q]) begin
        phase_q[cpu_id_q] <= PhDone;
      end else if (push_pre) begin
        if (pol != PolPrioP) slice_q[cpu_id_q] <= '0;
        order_q[ready_cnt_q[IdW-1:0]] <= cpu_id_q;
        phase_q[cpu_id_q] <= PhReady;
      end
    end
    if (admit_hit) begin
      order_q[ready_cnt_q[IdW-1:0]] <= scan_id;
      phase_q[scan_id] <= PhReady;
    end
    if (cmd_i.sel) begin
      if (sel_win) begin
        best_key_q <= key;
        best_pos_q <= scan_q;
        best_id_q  <= slot_id;
      end
    end
    if (cmd_i.shift && !sts_o.shift_last) begin
      order_q[scan_id] <= order_q[IdW'(scan_q + 1'b1)];
    end
    if (cmd_i.dispatch) phase_q[cur_id] <= PhRun;
    if (cmd_i.run && busy_q) begin
      if (ran_q[cpu_id_q] < 10'd1023) ran_q[cpu_id_q] <= ran_q[cpu_id_q] + 10'd1;
      if (rr && slice_q[cpu_id_q] < 8'd255)
        slice_q[cpu_id_q] <= slice_q[cpu_id_q] + 8'd1;
    end
    if (cmd_i.age && pol == PolRrAge && age_q[slot_id] < 8'd255) begin
      age_q[slot_id] <= age_q[slot_id] + 8'd1;
    end
  end

  // control state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_cnt_q   <= '0;
      loaded_q      <= '0;
      fin_q         <= '0;
      scan_q        <= '0;
      clock_q       <= '0;
      busy_q        <= 1'b0;
      cpu_id_q      <= '0;
      done_v_q      <= 1'b0;
      done_i_q      <= '0;
      rej_q         <= 1'b0;
      time_now_o    <= '0;
      run_valid_o   <= 1'b0;
      run_id_o      <= '0;
      done_valid_o  <= 1'b0;
      done_id_o     <= '0;
      all_done_o    <= 1'b1;
      load_reject_o <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        done_v_q <= 1'b0;
        done_i_q <= '0;
        if (loaded_q < CntW'(MaxProcs)) begin
          loaded_q <= loaded_q + 1'b1;
          rej_q    <= 1'b0;
        end else begin
          rej_q <= 1'b1;
        end
      end
      if (cmd_i.retire) begin
        done_v_q <= 1'b0;
        done_i_q <= '0;
        rej_q    <= 1'b0;
        if (busy_q) begin
          if (ran_q[cpu_id_q] == burst_q[cpu_id_q]) begin
            fin_q    <= fin_q + 1'b1;
            done_v_q <= 1'b1;
            done_i_q <= cpu_id_q;
            busy_q   <= 1'b0;
          end else if (push_pre) begin
            busy_q      <= 1'b0;
            ready_cnt_q <= ready_cnt_q + 1'b1;
          end
        end
      end
      if (admit_hit) begin
        ready_cnt_q <= ready_cnt_q + 1'b1;
      end
      if (cmd_i.dispatch) begin
        cpu_id_q    <= cur_id;
        busy_q      <= 1'b1;
        ready_cnt_q <= ready_cnt_q - 1'b1;
      end
      // end of select scan parks the index on the winning slot
      if (cmd_i.clr_scan) begin
        if (cmd_i.sel) scan_q <= sel_win ? scan_q : best_pos_q;
        else           scan_q <= '0;
      end else if (cmd_i.inc_scan) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.finish) begin
        time_now_o    <= clock_q;
        run_valid_o   <= 1'b0;
        run_id_o      <= '0;
        done_valid_o  <= 1'b0;
        done_id_o     <= '0;
        load_reject_o <= 1'b0;
        if (!cmd_i.tick) begin
          load_reject_o <= rej_q;
          all_done_o    <= (fin_q == loaded_q);
        end else begin
          all_done_o <= (fin_q == loaded_q);
          if (clock_q < horizon_i) begin
            run_valid_o  <= busy_q;
            run_id_o     <= busy_q ? 4'(cpu_id_q) : 4'd0;
            done_valid_o <= done_v_q;
            done_id_o    <= 4'(done_i_q);
            clock_q      <= clock_q + 10'd1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/cps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer for one load or tick. A load goes straight to the result; a tick
// runs retire, admit/select scans, ready-order compaction, run, aging, result.
// ----------------------------------------------------------------------------
module cps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode_i,
  output logic              out_valid,
  input  logic              out_ready,
  output cps_pkg::cps_cmd_t cmd_o,
  input  cps_pkg::cps_sts_t sts_i
);
  import cps_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StRetire, StAdmit, StSelStart, StSel, StShift,
    StDisp, StRun, StAge, StFinish, StOut
  } state_e;

  state_e state_q, state_d;
  logic   item_q, item_d;

  assign in_ready  = (state_q == StIdle) || (state_q == StOut && out_ready);
  assign out_valid = (state_q == StOut);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    item_d  = item_q;
    unique case (state_q)
      StIdle, StOut: begin
        if (state_q == StOut && out_ready) state_d = StIdle;
        // a load is written at its transfer edge
        if (in_valid && in_ready) begin
          item_d     = opcode_i;
          cmd_o.load = !opcode_i;
          state_d    = opcode_i ? StRetire : StFinish;
        end
      end
      StRetire: begin
        if (sts_i.tick_live) begin
          cmd_o.retire   = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d        = StAdmit;
        end else begin
          state_d = StFinish;
        end
      end
      StAdmit: begin
        cmd_o.admit = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.clr_scan = 1'b1;
          state_d        = StSelStart;
        end else begin
          cmd_o.inc_scan = 1'b1;
        end
      end
      StSelStart: begin
        // an empty table leaves the admit scan with nothing done
        if (!sts_i.busy && sts_i.ready_any) state_d = StSel;
        else state_d = StRun;
      end
      StSel: begin
        cmd_o.sel = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.clr_scan = 1'b1;
          state_d        = StShift;
        end else begin
          cmd_o.inc_scan = 1'b1;
        end
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_last) state_d = StDisp;
        else cmd_o.inc_scan = 1'b1;
      end
      StDisp: begin
        cmd_o.dispatch = 1'b1;
        cmd_o.clr_scan = 1'b1;
        state_d        = StRun;
      end
      StRun: begin
        cmd_o.run      = 1'b1;
        cmd_o.clr_scan = 1'b1;
        state_d        = sts_i.ready_any ? StAge : StFinish;
      end
      StAge: begin
        cmd_o.age = 1'b1;
        if (sts_i.scan_last) state_d = StFinish;
        else cmd_o.inc_scan = 1'b1;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        cmd_o.tick   = item_q;
        state_d      = StOut;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      item_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
    end
  end

endmodule

// ===== rtl/core/cpu_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// cpu_process_scheduler
// Tick-driven single-CPU scheduler over a table of loaded processes.
// ----------------------------------------------------------------------------
// Sequencing: a load and a tick past the horizon go straight to the result; a live
//   tick runs retire and the admit scan, then, with a dispatch, the select and
//   compaction scans, then run and, while slots are ready, the aging scan.
// Throughput: one item at a time; the next item is taken with the result transfer.
// Reset: asynchronous, clears counts, clock and CPU; policy 5, quantum 2,
//   horizon 50. Table contents are undefined until loaded.
module cpu_process_scheduler #(
  parameter int unsigned MaxProcs = cps_pkg::MaxProcsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode_i,
  input  logic [9:0] arrival_at_i,
  input  logic [9:0] burst_len_i,
  input  logic [7:0] base_prio_i,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] time_now_o,
  output logic       run_valid_o,
  output logic [3:0] run_id_o,
  output logic       done_valid_o,
  output logic [3:0] done_id_o,
  output logic       all_done_o,
  output logic       load_reject_o
);
  import cps_pkg::*;

  logic [2:0] policy_q;
  logic [7:0] quantum_q;
  logic [9:0] horizon_q;
  cps_cmd_t   cmd;
  cps_sts_t   sts;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= PolicyReset;
      quantum_q <= QuantumReset;
      horizon_q <= HorizonReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgPolicy:  policy_q  <= cfg_data[2:0];
        CfgQuantum: quantum_q <= cfg_data[7:0];
        CfgHorizon: horizon_q <= cfg_data;
        default: ;
      endcase
    end
  end

  cps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .opcode_i,
    .out_valid, .out_ready, .cmd_o(cmd), .sts_i(sts)
  );

  cps_datapath #(.MaxProcs(MaxProcs)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .policy_i(policy_q), .quantum_i(quantum_q), .horizon_i(horizon_q),
    .arrival_at_i, .burst_len_i, .base_prio_i,
    .time_now_o, .run_valid_o, .run_id_o, .done_valid_o, .done_id_o,
    .all_done_o, .load_reject_o
  );

endmodule
